/* design/bwtocc_pkg.sv */
// ----------------------------------------------------------------------------
// bwtocc_pkg
// Shared types, codes and helpers for the FM-index occurrence table.
// ----------------------------------------------------------------------------
package bwtocc_pkg;

  localparam int CMD_W  = 2;
  localparam int SYM_W  = 8;
  localparam int POS_W  = 12;
  localparam int CNT_W  = 13;
  localparam int STAT_W = 2;
  localparam int LANES  = 4;

  typedef logic [CNT_W-1:0]            count_t;
  typedef logic [LANES-1:0][CNT_W-1:0] row_t;
  typedef logic [1:0]                  lane_t;

  localparam count_t CNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BWT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNLOADED = 2'd2;

  localparam logic [SYM_W-1:0] SYM_A = 8'h41;
  localparam logic [SYM_W-1:0] SYM_C = 8'h43;
  localparam logic [SYM_W-1:0] SYM_G = 8'h47;
  localparam logic [SYM_W-1:0] SYM_T = 8'h54;

  localparam lane_t LANE_A = 2'd0;
  localparam lane_t LANE_C = 2'd1;
  localparam lane_t LANE_G = 2'd2;
  localparam lane_t LANE_T = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
  } in_beat_t;

  typedef struct packed {
    count_t            occurrence_count;
    count_t            less_count;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic  hit;
    lane_t lane;
  } lane_sel_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic lane_sel_t lane_of(input logic [SYM_W-1:0] sym);
    lane_sel_t sel;
    sel.hit  = 1'b1;
    sel.lane = LANE_A;
    unique case (sym)
      SYM_A:   sel.lane = LANE_A;
      SYM_C:   sel.lane = LANE_C;
      SYM_G:   sel.lane = LANE_G;
      SYM_T:   sel.lane = LANE_T;
      default: sel.hit  = 1'b0;
    endcase
    return sel;
  endfunction

  function automatic count_t less_for(input logic [SYM_W-1:0] sym, input count_t below_c,
                                      input count_t below_g, input count_t below_t);
    count_t res;
    if (sym <= SYM_A) begin
      res = '0;
    end else if (sym <= SYM_C) begin
      res = below_c;
    end else if (sym <= SYM_G) begin
      res = below_g;
    end else if (sym <= SYM_T) begin
      res = below_t;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

/* design/bwtocc_row_store.sv */
// ----------------------------------------------------------------------------
// bwtocc_row_store
// Count-row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bwtocc_row_store
  import bwtocc_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  row_t                     wr_row,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output row_t                     rd_row
);

  row_t mem [DEPTH];
  row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

/* design/bwt_occurrence_table.sv */
// ----------------------------------------------------------------------------
// bwt_occurrence_table
// FM-index occurrence table for DNA text: builds count rows and answers
// occurrence and less-than queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one command beat: a text symbol for the
//   less counts, a BWT symbol that appends one row of running A/C/G/T counts,
//   or a query at a row position. Every beat gives exactly one result beat on
//   out_valid/out_stall/out_data, in order.
//   An accepted beat passes the read stage, where the count-row memory is read,
//   and then the output register before its result appears on out_data.
//   One beat is taken per cycle while in_stall is low; each beat uses at most one write or one
//   read of the single count-row memory, and running counts live in flops.
//   An append beyond DEPTH rows returns status full and is dropped; a query
//   at a row not yet loaded returns status unloaded with zero counts.
//   While out_stall is high the output register holds its beat; one more beat
//   is taken into the read stage, then in_stall rises until the output drains.
//   Reset clears the loaded-row count, the running counts and the less
//   counts, so loading starts over; the memory is not swept and the block
//   takes beats from the first cycle after reset.
// ----------------------------------------------------------------------------
module bwt_occurrence_table
  import bwtocc_pkg::*;
#(
  parameter int DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int RW = $clog2(DEPTH + 1);
  localparam int CW = (RW > POS_W) ? RW : POS_W;

  logic [RW-1:0] rows_loaded_r, rows_loaded_nxt;
  row_t          running_r, running_nxt;
  count_t        below_c_r, below_c_nxt;
  count_t        below_g_r, below_g_nxt;
  count_t        below_t_r, below_t_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_occ_en_r;
  lane_t             s1_lane_r;
  count_t            s1_less_r;
  logic [STAT_W-1:0] s1_status_r;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;

  logic              in_acc, s1_adv;
  logic              full, query_ok;
  lane_sel_t         sel;
  logic [CW-1:0]     pos_ext, rows_ext;
  logic              wr_en, rd_en;
  logic              occ_en;
  count_t            less_val;
  logic [STAT_W-1:0] status_val;
  row_t              rd_row;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign sel      = lane_of(in_data.symbol);
  assign full     = (rows_loaded_r == RW'(DEPTH));
  assign pos_ext  = CW'(in_data.position);
  assign rows_ext = CW'(rows_loaded_r);
  assign query_ok = (pos_ext < rows_ext);

  assign wr_en = in_acc && (in_data.command == CMD_BWT) && !full;
  assign rd_en = in_acc && (in_data.command == CMD_QUERY) && query_ok;

  always_comb begin
    rows_loaded_nxt = rows_loaded_r;
    running_nxt     = running_r;
    below_c_nxt     = below_c_r;
    below_g_nxt     = below_g_r;
    below_t_nxt     = below_t_r;
    occ_en          = 1'b0;
    less_val        = '0;
    status_val      = STATUS_OK;
    case (in_data.command)
      CMD_TEXT: begin
        if (in_data.symbol == SYM_A) begin
          below_c_nxt = sat_inc(below_c_r);
          below_g_nxt = sat_inc(below_g_r);
          below_t_nxt = sat_inc(below_t_r);
        end else if (in_data.symbol == SYM_C) begin
          below_g_nxt = sat_inc(below_g_r);
          below_t_nxt = sat_inc(below_t_r);
        end else if (in_data.symbol == SYM_G) begin
          below_t_nxt = sat_inc(below_t_r);
        end
      end
      CMD_BWT: begin
        if (full) begin
          status_val = STATUS_FULL;
        end else begin
          if (sel.hit) begin
            running_nxt[sel.lane] = sat_inc(running_r[sel.lane]);
          end
          rows_loaded_nxt = rows_loaded_r + RW'(1);
        end
      end
      CMD_QUERY: begin
        if (query_ok) begin
          occ_en   = sel.hit;
          less_val = less_for(in_data.symbol, below_c_r, below_g_r, below_t_r);
        end else begin
          status_val = STATUS_UNLOADED;
        end
      end
      default: begin
      end
    endcase
  end

  bwtocc_row_store #(
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(rows_loaded_r[AW-1:0]),
    .wr_row (running_nxt),
    .rd_en  (rd_en),
    .rd_addr(pos_ext[AW-1:0]),
    .rd_row (rd_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_loaded_r <= '0;
      running_r     <= '0;
      below_c_r     <= '0;
      below_g_r     <= '0;
      below_t_r     <= '0;
    end else if (in_acc) begin
      rows_loaded_r <= rows_loaded_nxt;
      running_r     <= running_nxt;
      below_c_r     <= below_c_nxt;
      below_g_r     <= below_g_nxt;
      below_t_r     <= below_t_nxt;
    end
  end

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_occ_en_r <= occ_en;
      s1_lane_r   <= sel.lane;
      s1_less_r   <= less_val;
      s1_status_r <= status_val;
    end
    if (s1_adv) begin
      out_data_r.occurrence_count <= s1_occ_en_r ? rd_row[s1_lane_r] : '0;
      out_data_r.less_count       <= s1_less_r;
      out_data_r.status           <= s1_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rows_loaded_r <= RW'(DEPTH))
    else $error("loaded row count beyond depth");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> rows_loaded_r == $past(rows_loaded_r) + RW'(1))
    else $error("append did not advance the row count");

  a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.command == CMD_BWT && full) |=> $stable(rows_loaded_r) &&
      $stable(running_r))
    else $error("append at full store changed state");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked output");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> CW'(rows_loaded_r) > pos_ext)
    else $error("memory read of an unloaded row");
`endif

endmodule

/* tb/tb_bwt_occurrence_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bwt_occurrence_table
// Self-checking bench for the FM-index occurrence table. A scoreboard model
// follows every accepted command beat and predicts its result beat, which is
// checked field by field against the output channel in order. Runs a directed
// pass over the symbol ranges and special cases, then a mixed random pass with
// idle bursts on both channels that ends in a stretch without idling.
// ----------------------------------------------------------------------------
module tb_bwt_occurrence_table;
  import bwtocc_pkg::*;

  localparam int DEPTH        = 4096;
  localparam int RANDOM_ITEMS = 825;
  localparam int QUIET_ITEMS  = 100;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  bwt_occurrence_table #(.DEPTH(DEPTH)) DUT (.*);

  row_t      count_store [DEPTH];
  row_t      running_row;
  int        rows_loaded;
  count_t    less_c;
  count_t    less_g;
  count_t    less_t;
  out_beat_t expected_results [$];
  int        mismatches;
  bit        idle_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_beat_t mk_beat(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
                                       logic [POS_W-1:0] pos);
    in_beat_t b;
    b.command  = cmd;
    b.symbol   = sym;
    b.position = pos;
    return b;
  endfunction

  function automatic logic [SYM_W-1:0] random_symbol();
    logic [SYM_W-1:0] nucleotides [4];
    nucleotides = '{SYM_A, SYM_C, SYM_G, SYM_T};
    if ($urandom_range(0, 3) == 0) begin
      return SYM_W'($urandom);
    end
    return nucleotides[$urandom_range(0, 3)];
  endfunction

  function automatic count_t bump(count_t v);
    return (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

  function automatic int nucleotide_lane(logic [SYM_W-1:0] sym);
    case (sym)
      SYM_A:   return 0;
      SYM_C:   return 1;
      SYM_G:   return 2;
      SYM_T:   return 3;
      default: return -1;
    endcase
  endfunction

  function automatic out_beat_t predict_result(in_beat_t b);
    out_beat_t r;
    int        lane;
    r        = '0;
    r.status = STATUS_OK;
    lane     = nucleotide_lane(b.symbol);
    case (b.command)
      CMD_TEXT: begin
        if (b.symbol == SYM_A) begin
          less_c = bump(less_c);
        end
        if (b.symbol == SYM_A || b.symbol == SYM_C) begin
          less_g = bump(less_g);
        end
        if (b.symbol == SYM_A || b.symbol == SYM_C || b.symbol == SYM_G) begin
          less_t = bump(less_t);
        end
      end
      CMD_BWT: begin
        if (rows_loaded >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          if (lane >= 0) begin
            running_row[lane] = bump(running_row[lane]);
          end
          count_store[rows_loaded] = running_row;
          rows_loaded++;
        end
      end
      CMD_QUERY: begin
        if (int'(b.position) >= rows_loaded) begin
          r.status = STATUS_UNLOADED;
        end else begin
          if (lane >= 0) begin
            r.occurrence_count = count_store[b.position][lane];
          end
          if (b.symbol <= SYM_A) begin
            r.less_count = '0;
          end else if (b.symbol <= SYM_C) begin
            r.less_count = less_c;
          end else if (b.symbol <= SYM_G) begin
            r.less_count = less_g;
          end else if (b.symbol <= SYM_T) begin
            r.less_count = less_t;
          end else begin
            r.less_count = '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(in_beat_t b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_result(b));
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_beat_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result beat: occ %0d less %0d status %0d",
                   out_data.occurrence_count, out_data.less_count, out_data.status);
        end
      end else begin
        e = expected_results.pop_front();
        if (out_data.occurrence_count !== e.occurrence_count ||
            out_data.less_count !== e.less_count || out_data.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: occ exp %0d got %0d, less exp %0d got %0d, status exp %0d got %0d",
                     e.occurrence_count, out_data.occurrence_count,
                     e.less_count, out_data.less_count, e.status, out_data.status);
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic [SYM_W-1:0] probes [10];
    probes = '{8'h00, SYM_A, SYM_A + 8'd1, SYM_C, SYM_C + 8'd1, SYM_G, SYM_G + 8'd1,
               SYM_T, SYM_T + 8'd1, 8'hFF};
    idle_on = 1'b1;
    send_beat(mk_beat(CMD_QUERY, SYM_A, 12'd0));
    send_beat(mk_beat(CMD_QUERY, SYM_T, 12'hFFF));
    send_beat(mk_beat(CMD_NONE, SYM_A, 12'hFFF));
    send_beat(mk_beat(CMD_TEXT, SYM_A, 12'd0));
    send_beat(mk_beat(CMD_TEXT, SYM_C, 12'hFFF));
    send_beat(mk_beat(CMD_TEXT, SYM_G, 12'd0));
    send_beat(mk_beat(CMD_TEXT, SYM_T, 12'd0));
    send_beat(mk_beat(CMD_TEXT, 8'hFF, 12'd0));
    send_beat(mk_beat(CMD_BWT, SYM_A, 12'hFFF));
    send_beat(mk_beat(CMD_BWT, SYM_C, 12'd0));
    send_beat(mk_beat(CMD_BWT, SYM_G, 12'd0));
    send_beat(mk_beat(CMD_BWT, SYM_T, 12'd0));
    send_beat(mk_beat(CMD_BWT, 8'h00, 12'd0));
    send_beat(mk_beat(CMD_BWT, 8'hFF, 12'd0));
    foreach (probes[i]) begin
      send_beat(mk_beat(CMD_QUERY, probes[i], (i % 2) ? 12'd5 : 12'd0));
    end
    send_beat(mk_beat(CMD_QUERY, SYM_G, 12'd6));
  endtask

  task automatic test_random();
    in_beat_t b;
    int       pick;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < RANDOM_ITEMS - QUIET_ITEMS) && (((i / 100) % 3) != 2);
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      b    = mk_beat(CMD_TEXT, random_symbol(), POS_W'($urandom));
      if (pick < 5) begin
        b.command = CMD_NONE;
      end else if (pick < 30) begin
        b.command = CMD_TEXT;
      end else if (pick < 65) begin
        b.command = CMD_BWT;
      end else begin
        b.command = CMD_QUERY;
        if (rows_loaded > 0 && $urandom_range(0, 9) != 0) begin
          b.position = POS_W'($urandom_range(0, rows_loaded - 1));
        end
      end
      send_beat(b);
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    idle_on     = 1'b0;
    mismatches  = 0;
    running_row = '0;
    rows_loaded = 0;
    less_c      = '0;
    less_g      = '0;
    less_t      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
